>>> sv/vpa_pkg.sv
// shared constants and types for the variable partition allocator
package vpa_pkg;

  localparam int MaxSegments = 32;
  localparam int AddrBits    = 16;
  localparam int IdxBits     = $clog2(MaxSegments);
  localparam int CntBits     = $clog2(MaxSegments + 1);
  localparam int SizeBits    = AddrBits + 1;

  localparam logic [1:0] FitFirst  = 2'd0;
  localparam logic [1:0] FitBest   = 2'd1;
  localparam logic [1:0] FitWorst  = 2'd2;
  localparam logic [1:0] FitUnused = 2'd3;

  localparam logic [0:0] RegFitPolicy  = 1'b0;
  localparam logic [0:0] RegMemorySize = 1'b1;

  localparam logic OpFree  = 1'b0;
  localparam logic OpAlloc = 1'b1;

  typedef struct packed {
    logic                op;
    logic [15:0]         tag;
    logic [7:0]          owner;
    logic [SizeBits-1:0] size;
  } req_t;

endpackage

>>> sv/vpa_front.sv
// input stage: takes request words into a short queue toward the table engine
module vpa_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  vpa_pkg::req_t in_req,
  output logic          req_valid,
  output vpa_pkg::req_t req,
  input  logic          req_take
);

  vpa_pkg::req_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign full      = fill == 2'd2;
  assign req_valid = fill != 2'd0;
  assign req       = slot[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= in_req;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> sv/vpa_back.sv
// table engine: fit search, split or merge shift, listing of segments
module vpa_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  vpa_pkg::req_t             req,
  output logic                      req_take,
  input  logic                      cfg_we,
  input  logic                      cfg_sel,
  input  logic [vpa_pkg::SizeBits-1:0] cfg_data,
  output logic                      cfg_ready,
  output logic                      out_valid,
  input  logic                      out_take,
  output logic [15:0]               tag_echo,
  output logic [vpa_pkg::AddrBits-1:0] seg_first,
  output logic [vpa_pkg::AddrBits-1:0] seg_last_addr,
  output logic                      seg_busy,
  output logic [7:0]                seg_holder,
  output logic                      table_full,
  output logic                      last_of_run
);

  localparam int N  = vpa_pkg::MaxSegments;
  localparam int IB = vpa_pkg::IdxBits;
  localparam int CB = vpa_pkg::CntBits;
  localparam int AB = vpa_pkg::AddrBits;
  localparam int SB = vpa_pkg::SizeBits;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_APPLY = 6'b000100,
    S_SHIFT = 6'b001000,
    S_MERGE = 6'b010000,
    S_LIST  = 6'b100000
  } state_t;

  state_t        state;
  logic [AB-1:0] seg_start [N];
  logic [AB-1:0] seg_end   [N];
  logic [N-1:0]  seg_used;
  logic [7:0]    seg_owner [N];
  logic [CB-1:0] count;
  logic [1:0]    fit_policy;
  vpa_pkg::req_t cur;
  logic [CB-1:0] idx;
  logic          found;
  logic [IB-1:0] pick;
  logic [SB-1:0] plen;
  logic          full_flag;
  logic [CB-1:0] shift_to;
  logic          merge_next;
  logic          merge_prev;

  logic [IB-1:0] ix;
  logic [SB-1:0] len;
  logic          cand;
  logic          better;
  logic [SB-1:0] cfg_clip;

  assign ix     = idx[IB-1:0];
  assign len    = SB'(seg_end[ix]) - SB'(seg_start[ix]) + SB'(1);
  assign cand   = cur.op == vpa_pkg::OpAlloc ? (!seg_used[ix] && len >= cur.size)
                                             : (seg_used[ix] && seg_owner[ix] == cur.owner);
  assign better = !found || (fit_policy == vpa_pkg::FitBest && len < plen)
                         || (fit_policy == vpa_pkg::FitWorst && len > plen);
  // zero is taken as one unit, anything above the address space saturates
  assign cfg_clip = cfg_data == '0 ? SB'(1)
                  : (cfg_data > (SB'(1) << AB) ? (SB'(1) << AB) : cfg_data);

  assign req_take  = state == S_IDLE && !cfg_we;
  assign cfg_ready = state == S_IDLE;
  assign out_valid = state == S_LIST;
  assign tag_echo      = cur.tag;
  assign seg_first     = seg_start[ix];
  assign seg_last_addr = seg_end[ix];
  assign seg_busy      = seg_used[ix];
  assign seg_holder    = seg_used[ix] ? seg_owner[ix] : 8'd0;
  assign table_full    = full_flag;
  assign last_of_run   = idx + CB'(1) == count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fit_policy <= vpa_pkg::FitFirst;
      count      <= CB'(1);
      seg_used   <= '0;
      seg_start[0] <= '0;
      seg_end[0]   <= '1;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            if (cfg_sel == vpa_pkg::RegFitPolicy) begin
              fit_policy <= cfg_data[1:0];
            end else begin
              count        <= CB'(1);
              seg_used     <= '0;
              seg_start[0] <= '0;
              seg_end[0]   <= AB'(cfg_clip - SB'(1));
            end
          end else if (req_valid) begin
            cur       <= req;
            idx       <= '0;
            found     <= 1'b0;
            full_flag <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one segment per cycle
          if (idx == count) begin
            idx   <= '0;
            state <= S_APPLY;
          end else begin
            if (cur.op == vpa_pkg::OpAlloc) begin
              if (cand && better && cur.size != '0 && fit_policy != vpa_pkg::FitUnused) begin
                found <= 1'b1;
                pick  <= ix;
                plen  <= len;
                if (fit_policy == vpa_pkg::FitFirst) state <= S_APPLY;
              end
            end else if (cand && !found) begin
              found <= 1'b1;
              pick  <= ix;
              state <= S_APPLY;
            end
            idx <= idx + CB'(1);
          end
        end
        S_APPLY: begin
          idx <= '0;
          if (!found) begin
            state <= S_LIST;
          end else if (cur.op == vpa_pkg::OpAlloc) begin
            if (plen == cur.size) begin
              seg_used[pick]  <= 1'b1;
              seg_owner[pick] <= cur.owner;
              state           <= S_LIST;
            end else if (count >= CB'(N)) begin
              full_flag <= 1'b1;
              state     <= S_LIST;
            end else begin
              seg_used[pick]  <= 1'b1;
              seg_owner[pick] <= cur.owner;
              seg_end[pick] <= seg_start[pick] + AB'(cur.size - SB'(1));
              shift_to <= count;
              count    <= count + CB'(1);
              // pick+1 slot receives the remainder when the shift ends
              plen     <= SB'(seg_end[pick]);
              state    <= S_SHIFT;
            end
          end else begin
            seg_used[pick] <= 1'b0;
            merge_next <= CB'(pick) + CB'(1) < count && !seg_used[IB'(pick + IB'(1))];
            merge_prev <= pick != '0 && !seg_used[IB'(pick - IB'(1))];
            shift_to   <= CB'(pick) + CB'(1);
            state      <= S_MERGE;
          end
        end
        S_SHIFT: begin
          // move one entry up per cycle, then place the split remainder
          if (shift_to == CB'(pick) + CB'(1)) begin
            seg_start[shift_to[IB-1:0]] <= seg_start[pick] + AB'(cur.size);
            seg_end[shift_to[IB-1:0]]   <= AB'(plen);
            seg_used[shift_to[IB-1:0]]  <= 1'b0;
            state <= S_LIST;
          end else begin
            seg_start[shift_to[IB-1:0]] <= seg_start[IB'(shift_to - CB'(1))];
            seg_end[shift_to[IB-1:0]]   <= seg_end[IB'(shift_to - CB'(1))];
            seg_used[shift_to[IB-1:0]]  <= seg_used[IB'(shift_to - CB'(1))];
            seg_owner[shift_to[IB-1:0]] <= seg_owner[IB'(shift_to - CB'(1))];
            shift_to <= shift_to - CB'(1);
          end
        end
        S_MERGE: begin
          // absorb one free neighbor, close its gap one entry per cycle, repeat
          if (idx != '0) begin
            if (shift_to + CB'(1) < count) begin
              seg_start[shift_to[IB-1:0]] <= seg_start[IB'(shift_to + CB'(1))];
              seg_end[shift_to[IB-1:0]]   <= seg_end[IB'(shift_to + CB'(1))];
              seg_used[shift_to[IB-1:0]]  <= seg_used[IB'(shift_to + CB'(1))];
              seg_owner[shift_to[IB-1:0]] <= seg_owner[IB'(shift_to + CB'(1))];
              shift_to <= shift_to + CB'(1);
            end else begin
              count <= count - CB'(1);
              idx   <= '0;
            end
          end else if (merge_next) begin
            seg_end[pick] <= seg_end[IB'(pick + IB'(1))];
            merge_next    <= 1'b0;
            shift_to      <= CB'(pick) + CB'(1);
            idx           <= CB'(1);
          end else if (merge_prev) begin
            seg_end[IB'(pick - IB'(1))] <= seg_end[pick];
            merge_prev <= 1'b0;
            pick       <= pick - IB'(1);
            shift_to   <= CB'(pick);
            idx        <= CB'(1);
          end else begin
            state <= S_LIST;
          end
        end
        S_LIST: begin
          if (out_take) begin
            if (last_of_run) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + CB'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/variable_partition_allocator.sv
// top level of the variable partition allocator
// a taken request goes through the table scan, then any split shift or merge steps,
// to the first result; then one result per cycle while pop is held, one per segment
// (up to 32); requests are handled one at a time
// and a two-word queue buffers input; config is accepted only while the engine idles
// reset (rst, synchronous): policy first fit, 65536 units as one free segment
module variable_partition_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [15:0] request_tag,
  input  logic [7:0]  owner_id,
  input  logic [16:0] request_size,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] tag_echo,
  output logic [15:0] seg_first,
  output logic [15:0] seg_last_addr,
  output logic        seg_busy,
  output logic [7:0]  seg_holder,
  output logic        table_full,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  vpa_pkg::req_t in_req;
  vpa_pkg::req_t req;
  logic          req_valid;
  logic          req_take;
  logic          out_valid;

  assign in_req    = '{op: op, tag: request_tag, owner: owner_id, size: request_size};
  assign empty     = !out_valid;

  vpa_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_req(in_req),
    .req_valid(req_valid), .req(req), .req_take(req_take)
  );

  vpa_back u_back (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req(req), .req_take(req_take),
    .cfg_we(cfg_valid), .cfg_sel(cfg_index), .cfg_data(cfg_data), .cfg_ready(cfg_ready),
    .out_valid(out_valid), .out_take(pop), .tag_echo(tag_echo),
    .seg_first(seg_first), .seg_last_addr(seg_last_addr), .seg_busy(seg_busy),
    .seg_holder(seg_holder), .table_full(table_full), .last_of_run(last_of_run)
  );

  a_holder_free: assert property (@(posedge clk) disable iff (rst)
    !empty && !seg_busy |-> seg_holder == 8'd0)
    else $error("free segment shows a holder");

  a_list_ordered: assert property (@(posedge clk) disable iff (rst)
    !empty |-> seg_last_addr >= seg_first)
    else $error("segment ends before it starts");

  a_tag_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !$past(empty) && !$past(last_of_run) && !$past(rst) |-> $stable(tag_echo))
    else $error("tag changed within a listing");

endmodule

>>> test/variable_partition_allocator_tb.sv
// testbench for the variable partition allocator: directed table plus random requests
module variable_partition_allocator_tb;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        op;
  logic [15:0] request_tag;
  logic [7:0]  owner_id;
  logic [16:0] request_size;
  logic        empty;
  logic        pop;
  logic [15:0] tag_echo;
  logic [15:0] seg_first;
  logic [15:0] seg_last_addr;
  logic        seg_busy;
  logic [7:0]  seg_holder;
  logic        table_full;
  logic        last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [16:0] cfg_data;

  variable_partition_allocator uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .request_tag(request_tag), .owner_id(owner_id), .request_size(request_size),
    .empty(empty), .pop(pop), .tag_echo(tag_echo), .seg_first(seg_first),
    .seg_last_addr(seg_last_addr), .seg_busy(seg_busy), .seg_holder(seg_holder),
    .table_full(table_full), .last_of_run(last_of_run), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] first;
    logic [15:0] last;
    logic        busy;
    logic [7:0]  holder;
    logic        tfull;
    logic        fin;
  } listing_t;

  typedef struct {
    logic        op;
    logic [7:0]  owner;
    logic [16:0] size;
    int          nseg;   // expected segment count, -1 when not typed in
    logic        tfull;
  } row_t;

  // predictor state
  logic [15:0] pm_start [vpa_pkg::MaxSegments];
  logic [15:0] pm_end   [vpa_pkg::MaxSegments];
  logic        pm_used  [vpa_pkg::MaxSegments];
  logic [7:0]  pm_owner [vpa_pkg::MaxSegments];
  int          pm_count;
  logic [1:0]  pm_policy;
  logic [16:0] pm_size;

  listing_t listing_q[$];
  int  errors;
  int  words_in, words_out, full_listings;
  int  cycle;
  int  send_idle, recv_idle;
  int  last_nseg;
  logic last_tfull;
  logic hold_recv;
  logic [15:0] next_tag;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 2000000) begin
      $display("timeout at cycle %0d", cycle);
      $display("[variable_partition_allocator] ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors < 40) $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle);
  endtask

  function automatic longint seg_len(int i);
    return longint'(pm_end[i]) - longint'(pm_start[i]) + 1;
  endfunction

  task automatic table_rebuild();
    for (int i = 0; i < vpa_pkg::MaxSegments; i++) begin
      pm_start[i] = '0; pm_end[i] = '0; pm_used[i] = 0; pm_owner[i] = '0;
    end
    pm_end[0] = 16'(pm_size - 1);
    pm_count = 1;
  endtask

  task automatic drop_segment(int k);
    for (int i = k; i + 1 < pm_count; i++) begin
      pm_start[i] = pm_start[i+1]; pm_end[i] = pm_end[i+1];
      pm_used[i] = pm_used[i+1]; pm_owner[i] = pm_owner[i+1];
    end
    pm_count--;
  endtask

  // returns 1 when a split was refused for lack of table room
  function automatic logic carve(logic [7:0] who, logic [16:0] want);
    int pick;
    logic found;
    longint plen, len;
    pick = 0; found = 0; plen = 0;
    if (want == 0 || pm_policy > vpa_pkg::FitWorst) return 0;
    for (int i = 0; i < pm_count; i++) begin
      len = seg_len(i);
      if (pm_used[i] || len < want) continue;
      if (pm_policy == vpa_pkg::FitFirst) begin
        pick = i; plen = len; found = 1;
        break;
      end
      if (!found || (pm_policy == vpa_pkg::FitBest && len < plen) ||
          (pm_policy == vpa_pkg::FitWorst && len > plen)) begin
        pick = i; plen = len; found = 1;
      end
    end
    if (!found) return 0;
    if (plen == want) begin
      pm_used[pick] = 1; pm_owner[pick] = who;
      return 0;
    end
    if (pm_count >= vpa_pkg::MaxSegments) return 1;
    for (int i = pm_count; i > pick + 1; i--) begin
      pm_start[i] = pm_start[i-1]; pm_end[i] = pm_end[i-1];
      pm_used[i] = pm_used[i-1]; pm_owner[i] = pm_owner[i-1];
    end
    pm_end[pick+1] = pm_end[pick];
    pm_used[pick+1] = 0; pm_owner[pick+1] = '0;
    pm_count++;
    pm_end[pick] = 16'(32'(pm_start[pick]) + want - 1);
    pm_used[pick] = 1; pm_owner[pick] = who;
    pm_start[pick+1] = 16'(32'(pm_start[pick]) + want);
    return 0;
  endfunction

  task automatic release_owner(logic [7:0] who);
    int f;
    for (f = 0; f < pm_count; f++)
      if (pm_used[f] && pm_owner[f] == who) break;
    if (f >= pm_count) return;
    pm_used[f] = 0; pm_owner[f] = '0;
    if (f + 1 < pm_count && !pm_used[f+1]) begin
      pm_end[f] = pm_end[f+1];
      drop_segment(f + 1);
    end
    if (f > 0 && !pm_used[f-1]) begin
      pm_end[f-1] = pm_end[f];
      drop_segment(f);
    end
  endtask

  task automatic predict_listing(logic o, logic [15:0] tag, logic [7:0] who, logic [16:0] sz);
    logic tf;
    listing_t w;
    tf = 0;
    if (o == vpa_pkg::OpAlloc) tf = carve(who, sz);
    else release_owner(who);
    if (tf) full_listings++;
    last_nseg = pm_count;
    last_tfull = tf;
    for (int i = 0; i < pm_count; i++) begin
      w.tag = tag; w.first = pm_start[i]; w.last = pm_end[i];
      w.busy = pm_used[i]; w.holder = pm_used[i] ? pm_owner[i] : 8'd0;
      w.tfull = tf; w.fin = (i + 1 == pm_count);
      listing_q.push_back(w);
    end
  endtask

  // result side
  always @(posedge clk) begin
    listing_t want;
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        words_out++;
        if (listing_q.size() == 0) report("unexpected word", tag_echo, 0);
        else begin
          want = listing_q.pop_front();
          if (tag_echo != want.tag) report("tag_echo", tag_echo, want.tag);
          if (seg_first != want.first) report("seg_first", seg_first, want.first);
          if (seg_last_addr != want.last) report("seg_last_addr", seg_last_addr, want.last);
          if (seg_busy != want.busy) report("seg_busy", seg_busy, want.busy);
          if (seg_holder != want.holder) report("seg_holder", seg_holder, want.holder);
          if (table_full != want.tfull) report("table_full", table_full, want.tfull);
          if (last_of_run != want.fin) report("last_of_run", last_of_run, want.fin);
        end
      end
      pop <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end
  end

  // push stays high after the accepting edge until the next send or drain drives it
  task automatic send(logic o, logic [7:0] who, logic [16:0] sz);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1; op <= o; request_tag <= next_tag; owner_id <= who; request_size <= sz;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_listing(o, next_tag, who, sz);
    words_in++;
    next_tag++;
  endtask

  task automatic drain();
    push <= 0;
    while (listing_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] val);
    logic [16:0] v;
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == vpa_pkg::RegFitPolicy) pm_policy = val[1:0];
    else begin
      v = val;
      if (v == 0) v = 1;
      if (v > 17'd65536) v = 17'd65536;
      pm_size = v;
      table_rebuild();
    end
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // typed rows: segment count and table_full read off at a glance
  task automatic check_row(row_t r);
    if (r.nseg >= 0 && last_nseg != r.nseg) report("segment count", last_nseg, r.nseg);
    if (r.nseg >= 0 && last_tfull != r.tfull) report("typed table_full", last_tfull, r.tfull);
  endtask

  task automatic random_phase(int n);
    logic o;
    logic [16:0] sz;
    for (int k = 0; k < n; k++) begin
      o = ($urandom_range(99) < 60) ? vpa_pkg::OpAlloc : vpa_pkg::OpFree;
      case ($urandom_range(9))
        0: sz = 17'($urandom_range(131071));
        1: sz = 17'(pm_size);
        2, 3: sz = 17'($urandom_range(pm_size > 64 ? 64 : pm_size));
        default: sz = 17'($urandom_range(pm_size > 4096 ? 4096 : pm_size));
      endcase
      send(o, 8'($urandom_range(255) & ($urandom_range(1) ? 8'hff : 8'h0f)), sz);
    end
  endtask

  row_t rows[$];

  initial begin
    rst = 1; push = 0; op = 0; request_tag = 0; owner_id = 0; request_size = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0; hold_recv = 0;
    errors = 0; words_in = 0; words_out = 0; full_listings = 0;
    last_nseg = 0; last_tfull = 0;
    next_tag = 16'hfffe;
    send_idle = 32; recv_idle = 87;
    pm_policy = vpa_pkg::FitFirst; pm_size = 17'd65536;
    table_rebuild();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed rows from reset: first fit, 65536 units
    rows = '{
      '{vpa_pkg::OpAlloc, 8'h00, 17'd65536, 1, 0},   // whole memory
      '{vpa_pkg::OpFree,  8'h00, 17'd0,     1, 0},
      '{vpa_pkg::OpAlloc, 8'hff, 17'd0,     1, 0},   // zero size
      '{vpa_pkg::OpAlloc, 8'h01, 17'd1,     2, 0},
      '{vpa_pkg::OpAlloc, 8'h02, 17'd100,   3, 0},
      '{vpa_pkg::OpAlloc, 8'h03, 17'd1,     4, 0},
      '{vpa_pkg::OpAlloc, 8'h04, 17'd131071, 4, 0},  // no fitting segment
      '{vpa_pkg::OpFree,  8'h77, 17'h1ffff, 4, 0},   // no matching owner
      '{vpa_pkg::OpFree,  8'h02, 17'd0,     4, 0},
      '{vpa_pkg::OpFree,  8'h01, 17'd0,     3, 0},   // merges with right neighbor
      '{vpa_pkg::OpFree,  8'h03, 17'd0,     1, 0}
    };
    foreach (rows[i]) begin
      send(rows[i].op, rows[i].owner, rows[i].size);
      check_row(rows[i]);
    end
    drain();

    // fill the table: full flag
    write_reg(vpa_pkg::RegMemorySize, 17'd100);
    for (int i = 0; i < 33; i++) begin
      send(vpa_pkg::OpAlloc, 8'(i), 17'd1);
      if (i == 32) check_row('{vpa_pkg::OpAlloc, 8'(i), 17'd1, 32, 1});
    end
    send(vpa_pkg::OpAlloc, 8'h55, 17'd69);  // exact fit of the last free piece
    drain();

    // policies over a fragmented table, including the unused one
    for (int p = 0; p < 4; p++) begin
      write_reg(vpa_pkg::RegFitPolicy, 17'(p));
      write_reg(vpa_pkg::RegMemorySize, 17'd1000);
      send(vpa_pkg::OpAlloc, 8'h10, 17'd50);  send(vpa_pkg::OpAlloc, 8'h11, 17'd10);
      send(vpa_pkg::OpAlloc, 8'h12, 17'd300); send(vpa_pkg::OpAlloc, 8'h13, 17'd5);
      send(vpa_pkg::OpFree, 8'h10, 0); send(vpa_pkg::OpFree, 8'h12, 0);
      send(vpa_pkg::OpAlloc, 8'h20, 17'd8);
      drain();
    end

    write_reg(vpa_pkg::RegMemorySize, 17'd0);   // taken as one unit
    send(vpa_pkg::OpAlloc, 8'h01, 17'd1);
    drain();

    // long receiver hold: block fills and stalls its input
    fork
      begin
        hold_recv = 1;
        repeat (1500) @(posedge clk);
        hold_recv = 0;
      end
      begin
        write_reg(vpa_pkg::RegMemorySize, 17'd4096);
        random_phase(10);
        drain();
      end
    join

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 87; recv_idle = 32; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      write_reg(vpa_pkg::RegFitPolicy, 17'($urandom_range(2)));
      write_reg(vpa_pkg::RegMemorySize, ph == 0 ? 17'd65536 : 17'($urandom_range(256, 65536)));
      random_phase(30);
      drain();   // sender pauses until every word has come
      write_reg(vpa_pkg::RegMemorySize, 17'd512);
      random_phase(60);
      drain();
    end

    $display("covered %0d requests, %0d listing words, %0d full-table listings",
             words_in, words_out, full_listings);
    $display("policies first, best, worst and unused; sizes 1 to 65536");
    if (errors == 0) $display("[variable_partition_allocator] OK");
    else $display("[variable_partition_allocator] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
sv/vpa_pkg.sv
sv/vpa_front.sv
sv/vpa_back.sv
sv/variable_partition_allocator.sv
test/variable_partition_allocator_tb.sv
